// ===== sv/msr_pkg.sv =====
// shared types and constants of the motor speed ramp block
package msr_pkg;
	localparam int RateW = 28;
	localparam int LimW = 23;
	localparam int RatioW = 16;
	localparam int SpdW = 24;
	localparam int PosW = 48;
	localparam int DtW = 21;
	localparam int CfgW = 28;
	localparam int CfgIdxW = 3;
	localparam logic [31:0] LcgMul = 32'd1664525;
	localparam logic [31:0] LcgAdd = 32'd1013904223;
	localparam logic [31:0] SeedDefault = 32'h12345678;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0, OP_TARGET = 3'd1, OP_ENABLE = 3'd2,
		OP_FAULT = 3'd3, OP_POS_RESET = 3'd4, OP_SEED = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		CFG_SP_ACC = 3'd0, CFG_SP_DEC = 3'd1, CFG_MO_ACC = 3'd2,
		CFG_MO_DEC = 3'd3, CFG_LIMIT = 3'd4, CFG_RATIO = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic load;      // capture input item and apply command ops
		logic sp_mul;
		logic sp_upd;
		logic mo_mul;
		logic mo_upd;
		logic band_mul;
		logic lcg;
		logic noise_mul;
		logic noise_upd;
		logic pos_mul;
		logic pos_upd;
	} cmd_t;

	typedef struct packed {
		logic is_tick;   // operation is a tick with nonzero length
		logic noise_on;  // ratio nonzero and actual equals setpoint
		logic band_nz;
	} stat_t;
endpackage

// ===== sv/msr_ctrl.sv =====
// sequencer of the motor speed ramp block
module msr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  msr_pkg::stat_t  stat,
	output msr_pkg::cmd_t   cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SP_MUL, S_SP_UPD, S_MO_MUL, S_MO_UPD, S_BAND,
		S_LCG, S_NMUL, S_NUPD, S_PMUL, S_PUPD, S_OUT
	} state_t;

	state_t state_q;

	// input is taken once the previous result has been handed off
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_SP_MUL: cmd.sp_mul = 1'b1;
			S_SP_UPD: cmd.sp_upd = 1'b1;
			S_MO_MUL: cmd.mo_mul = 1'b1;
			S_MO_UPD: cmd.mo_upd = 1'b1;
			S_BAND:   cmd.band_mul = 1'b1;
			S_LCG:    cmd.lcg = 1'b1;
			S_NMUL:   cmd.noise_mul = 1'b1;
			S_NUPD:   cmd.noise_upd = 1'b1;
			S_PMUL:   cmd.pos_mul = 1'b1;
			S_PUPD:   cmd.pos_upd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECODE;
				S_DECODE: state_q <= stat.is_tick ? S_SP_MUL : S_OUT;
				S_SP_MUL: state_q <= S_SP_UPD;
				S_SP_UPD: state_q <= S_MO_MUL;
				S_MO_MUL: state_q <= S_MO_UPD;
				S_MO_UPD: state_q <= S_BAND;
				// actual speed is settled here, so the noise check sees the slewed value
				S_BAND:   state_q <= stat.noise_on ? S_LCG : S_PMUL;
				S_LCG:    state_q <= stat.band_nz ? S_NMUL : S_PMUL;
				S_NMUL:   state_q <= S_NUPD;
				S_NUPD:   state_q <= S_PMUL;
				S_PMUL:   state_q <= S_PUPD;
				S_PUPD:   state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_DECODE : S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE || state_q == S_OUT))
		else $error("item loaded while busy");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sp_mul, cmd.sp_upd, cmd.mo_mul, cmd.mo_upd, cmd.band_mul,
			cmd.lcg, cmd.noise_mul, cmd.noise_upd, cmd.pos_mul, cmd.pos_upd}))
		else $error("two datapath steps at once");
endmodule

// ===== sv/msr_dp.sv =====
// datapath of the motor speed ramp block: state registers, shared multiplier
module msr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [msr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [msr_pkg::CfgW-1:0]    cfg_data,
	input  logic [2:0]                  operation,
	input  logic [msr_pkg::DtW-1:0]     tick_length,
	input  logic signed [msr_pkg::SpdW-1:0] target_speed,
	input  logic                        flag,
	input  logic [31:0]                 new_seed,
	input  msr_pkg::cmd_t               cmd,
	output msr_pkg::stat_t              stat,
	output logic signed [msr_pkg::SpdW-1:0] requested_speed,
	output logic signed [msr_pkg::SpdW-1:0] setpoint_speed,
	output logic signed [msr_pkg::SpdW-1:0] actual_speed,
	output logic signed [msr_pkg::PosW-1:0] position,
	output logic                        running,
	output logic                        fault_active
);
	localparam int SW = msr_pkg::SpdW;

	logic [msr_pkg::RateW-1:0] sp_acc_q, sp_dec_q, mo_acc_q, mo_dec_q;
	logic [msr_pkg::LimW-1:0] limit_q;
	logic [msr_pkg::RatioW-1:0] ratio_q;

	logic signed [SW-1:0] req_q, sp_q, act_q;
	logic [msr_pkg::PosW-1:0] pos_q;
	logic [31:0] seed_q;
	logic en_q, flt_q;
	logic [msr_pkg::DtW-1:0] dt_q;
	logic tick_q;
	logic [48:0] prod_q;       // shared product register
	logic [SW-1:0] band_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_acc_q <= 28'd256000;
			sp_dec_q <= 28'd256000;
			mo_acc_q <= 28'd204800;
			mo_dec_q <= 28'd204800;
			limit_q <= 23'd768000;
			ratio_q <= 16'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msr_pkg::CFG_SP_ACC: sp_acc_q <= cfg_data;
				msr_pkg::CFG_SP_DEC: sp_dec_q <= cfg_data;
				msr_pkg::CFG_MO_ACC: mo_acc_q <= cfg_data;
				msr_pkg::CFG_MO_DEC: mo_dec_q <= cfg_data;
				msr_pkg::CFG_LIMIT:  limit_q <= cfg_data[msr_pkg::LimW-1:0];
				msr_pkg::CFG_RATIO:  ratio_q <= cfg_data[msr_pkg::RatioW-1:0];
				default: ;
			endcase
		end
	end

	// rate selection for one slew
	function automatic logic [msr_pkg::RateW-1:0] pick_rate(
		input logic signed [SW-1:0] cur, input logic signed [SW-1:0] tgt,
		input logic [msr_pkg::RateW-1:0] acc, input logic [msr_pkg::RateW-1:0] dec);
		logic same;
		logic [SW:0] ac, at;
		same = (!cur[SW-1] && !tgt[SW-1]) || (cur <= 0 && tgt <= 0);
		ac = cur[SW-1] ? -{cur[SW-1], cur} : {1'b0, cur};
		at = tgt[SW-1] ? -{tgt[SW-1], tgt} : {1'b0, tgt};
		if (cur == tgt) return '0;
		else if (cur == 0) return acc;
		else if (same && at > ac) return acc;
		else return dec;
	endfunction

	// step toward target by at most md
	function automatic logic signed [SW-1:0] step_to(
		input logic signed [SW-1:0] cur, input logic signed [SW-1:0] tgt,
		input logic [28:0] md);
		logic signed [30:0] err, smd;
		err = 31'(tgt) - 31'(cur);
		smd = $signed({2'b0, md});
		if (err > smd) return SW'(31'(cur) + smd);
		else if (err < -smd) return SW'(31'(cur) - smd);
		else return tgt;
	endfunction

	logic signed [SW-1:0] goal;
	assign goal = (en_q && !flt_q) ? req_q : '0;

	logic [28:0] md;
	assign md = prod_q[48:20];

	logic signed [SW-1:0] sp_abs_src;
	logic [SW-1:0] sp_abs;
	assign sp_abs_src = sp_q;
	assign sp_abs = sp_abs_src[SW-1] ? SW'(-sp_abs_src) : sp_abs_src;

	// noise offset: (m - 2^23) * band, floor by 2^23
	logic signed [24:0] noise_off;
	logic signed [25:0] noise_v;
	logic signed [SW-1:0] lim_pos, lim_neg, tgt_cl;
	logic signed [49:0] pos_prod;
	logic signed [49:0] pos_step;
	assign noise_off = $signed(prod_q[47:23]);
	assign noise_v = 26'(sp_q) + 26'(noise_off);
	assign lim_pos = $signed({1'b0, limit_q});
	assign lim_neg = -lim_pos;
	assign tgt_cl = (target_speed > lim_pos) ? lim_pos :
		(target_speed < lim_neg) ? lim_neg : target_speed;
	assign pos_prod = $signed({prod_q[48], prod_q});
	// floor division by 60*4096: shift by 14, then floor by 15 via reciprocal
	// negative values go through the complement, floor(x/15) = ~floor(~x/15)
	logic signed [37:0] q14;
	logic signed [37:0] q15;
	logic [31:0] qa;
	logic [63:0] qm;
	logic [28:0] qd;
	assign q14 = 38'(pos_prod >>> 14);
	assign qa = q14[37] ? ~q14[31:0] : q14[31:0];
	assign qm = qa * 32'h88888889;
	assign qd = qm[63:35];
	assign q15 = q14[37] ? ~$signed({9'b0, qd}) : $signed({9'b0, qd});
	assign pos_step = 50'(q15);

	assign stat.is_tick = tick_q;
	assign stat.noise_on = (ratio_q != '0) && (act_q == sp_q);
	assign stat.band_nz = (band_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			sp_q <= '0;
			act_q <= '0;
			pos_q <= '0;
			seed_q <= msr_pkg::SeedDefault;
			en_q <= 1'b0;
			flt_q <= 1'b0;
			tick_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				tick_q <= (operation == msr_pkg::OP_TICK) && (tick_length != '0);
				unique case (operation)
					msr_pkg::OP_TARGET: if (!flt_q) req_q <= tgt_cl;
					msr_pkg::OP_ENABLE: begin
						if (!flag) en_q <= 1'b0;
						else if (!flt_q) en_q <= 1'b1;
					end
					msr_pkg::OP_FAULT: begin
						flt_q <= flag;
						if (flag) en_q <= 1'b0;
					end
					msr_pkg::OP_POS_RESET: pos_q <= '0;
					msr_pkg::OP_SEED: seed_q <= (new_seed != '0) ? new_seed
						: msr_pkg::SeedDefault;
					default: ;
				endcase
			end
			if (cmd.sp_upd) sp_q <= step_to(sp_q, goal, md);
			if (cmd.mo_upd) act_q <= step_to(act_q, sp_q, md);
			if (cmd.lcg) begin
				if (band_q != '0)
					seed_q <= ((seed_q == '0) ? msr_pkg::SeedDefault : seed_q)
						* msr_pkg::LcgMul + msr_pkg::LcgAdd;
			end
			if (cmd.noise_upd) begin
				if (noise_v > 26'sd8388607) act_q <= 24'sh7FFFFF;
				else if (noise_v < -26'sd8388608) act_q <= 24'sh800000;
				else act_q <= SW'(noise_v);
			end
			if (cmd.pos_upd) pos_q <= pos_q + pos_step[msr_pkg::PosW-1:0];
		end
	end

	// payload registers: shared multiplier, one product per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) dt_q <= tick_length;
		if (cmd.sp_mul)
			prod_q <= 49'(pick_rate(sp_q, goal, sp_acc_q, sp_dec_q) * dt_q);
		if (cmd.mo_mul)
			prod_q <= 49'(pick_rate(act_q, sp_q, mo_acc_q, mo_dec_q) * dt_q);
		if (cmd.band_mul) band_q <= SW'((40'(sp_abs) * ratio_q) >> 16);
		if (cmd.noise_mul)
			prod_q <= 49'($signed({1'b0, seed_q[31:8]} - 25'sd8388608)
				* $signed({1'b0, band_q}));
		if (cmd.pos_mul) prod_q <= 49'(act_q * $signed({1'b0, dt_q}));
	end

	assign requested_speed = req_q;
	assign setpoint_speed = sp_q;
	assign actual_speed = act_q;
	assign position = pos_q;
	assign running = en_q && !flt_q;
	assign fault_active = flt_q;

	a_en_flt: assert property (@(posedge clk) disable iff (!arst_n)
		flt_q |-> !en_q) else $error("enabled while faulted");
	a_req_lim: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load) && $past(operation) == msr_pkg::OP_TARGET && !$past(flt_q)
		&& !$past(cfg_we) |-> req_q <= lim_pos && req_q >= lim_neg)
		else $error("request outside limit");
	a_seed_nz: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load) && $past(operation) == msr_pkg::OP_SEED
		|-> seed_q != '0) else $error("seed left at zero");
endmodule

// ===== sv/motor_speed_ramp_model.sv =====
// motor speed ramp block top level: sequencer plus datapath
// command items pass from the decode state straight to the result; ticks also run the
// slew, band, optional noise and position steps. Items do not overlap, as the single shared
// multiplier is used by each tick up to five times in sequence
// reset: arst_n clears state, loads register defaults and the default seed
// the next item is taken in the cycle its predecessor's result is taken
module motor_speed_ramp_model (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [msr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [msr_pkg::CfgW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  operation,
	input  logic [msr_pkg::DtW-1:0]     tick_length,
	input  logic signed [msr_pkg::SpdW-1:0] target_speed,
	input  logic                        flag,
	input  logic [31:0]                 new_seed,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [msr_pkg::SpdW-1:0] requested_speed,
	output logic signed [msr_pkg::SpdW-1:0] setpoint_speed,
	output logic signed [msr_pkg::SpdW-1:0] actual_speed,
	output logic signed [msr_pkg::PosW-1:0] position,
	output logic                        running,
	output logic                        fault_active
);
	msr_pkg::cmd_t cmd;
	msr_pkg::stat_t stat;

	msr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	msr_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .operation, .tick_length,
		.target_speed, .flag, .new_seed, .cmd, .stat, .requested_speed,
		.setpoint_speed, .actual_speed, .position, .running, .fault_active
	);
endmodule

// ===== sim/tb.sv =====
// testbench for the motor speed ramp block: directed and random items against a predictor
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [msr_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [msr_pkg::CfgW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [msr_pkg::DtW-1:0] tick_length = '0;
	logic signed [msr_pkg::SpdW-1:0] target_speed = '0;
	logic flag = 1'b0;
	logic [31:0] new_seed = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [msr_pkg::SpdW-1:0] requested_speed, setpoint_speed, actual_speed;
	logic signed [msr_pkg::PosW-1:0] position;
	logic running, fault_active;

	motor_speed_ramp_model uut (.*);

	typedef struct packed {
		logic signed [msr_pkg::SpdW-1:0] req;
		logic signed [msr_pkg::SpdW-1:0] sp;
		logic signed [msr_pkg::SpdW-1:0] act;
		logic signed [msr_pkg::PosW-1:0] pos;
		logic run;
		logic flt;
	} speed_state_t;

	speed_state_t expected_q[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_off = 0;

	// predictor state
	logic [27:0] rate_reg[6];
	logic signed [msr_pkg::SpdW-1:0] m_req, m_sp, m_act;
	logic [msr_pkg::PosW-1:0] m_pos;
	logic [31:0] m_seed;
	logic m_en, m_flt;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic signed [msr_pkg::SpdW-1:0] slew_toward(
			logic signed [msr_pkg::SpdW-1:0] cur, logic signed [msr_pkg::SpdW-1:0] tgt,
			logic [27:0] acc, logic [27:0] dec, logic [msr_pkg::DtW-1:0] dt);
		longint err, md, c, t;
		logic [27:0] r;
		bit same;
		c = cur;
		t = tgt;
		err = t - c;
		same = (c >= 0 && t >= 0) || (c <= 0 && t <= 0);
		if (c == t) r = '0;
		else if (c == 0) r = acc;
		else if (same && (t < 0 ? -t : t) > (c < 0 ? -c : c)) r = acc;
		else r = dec;
		md = (longint'(r) * longint'(dt)) >>> 20;
		if (err > md) return msr_pkg::SpdW'(c + md);
		if (err < -md) return msr_pkg::SpdW'(c - md);
		return tgt;
	endfunction

	function automatic longint floor_by(longint x, longint d);
		if (x >= 0) return x / d;
		return -((-x + d - 1) / d);
	endfunction

	function automatic void advance_tick(logic [msr_pkg::DtW-1:0] dt);
		logic signed [msr_pkg::SpdW-1:0] goal;
		longint band, m, v, sp;
		logic [31:0] s;
		goal = (m_en && !m_flt) ? m_req : '0;
		m_sp = slew_toward(m_sp, goal, rate_reg[msr_pkg::CFG_SP_ACC],
			rate_reg[msr_pkg::CFG_SP_DEC], dt);
		m_act = slew_toward(m_act, m_sp, rate_reg[msr_pkg::CFG_MO_ACC],
			rate_reg[msr_pkg::CFG_MO_DEC], dt);
		if (rate_reg[msr_pkg::CFG_RATIO] != 0 && m_act == m_sp) begin
			sp = m_sp;
			band = ((sp < 0 ? -sp : sp) * longint'(rate_reg[msr_pkg::CFG_RATIO])) >>> 16;
			if (band != 0) begin
				s = (m_seed == 0) ? msr_pkg::SeedDefault : m_seed;
				m_seed = s * msr_pkg::LcgMul + msr_pkg::LcgAdd;
				m = longint'((m_seed >> 8) & 32'h00FFFFFF);
				v = sp + floor_by((m - 8388608) * band, 64'sd8388608);
				if (v > 8388607) v = 8388607;
				if (v < -8388608) v = -8388608;
				m_act = msr_pkg::SpdW'(v);
			end
		end
		m_pos = m_pos + msr_pkg::PosW'(floor_by(longint'(m_act) * longint'(dt), 60 * 4096));
	endfunction

	function automatic speed_state_t predict_item(logic [2:0] op,
			logic [msr_pkg::DtW-1:0] dt, logic signed [msr_pkg::SpdW-1:0] tgt, logic f,
			logic [31:0] seed);
		speed_state_t r;
		longint lim, t;
		lim = rate_reg[msr_pkg::CFG_LIMIT];
		t = tgt;
		case (op)
			msr_pkg::OP_TICK: if (dt != 0) advance_tick(dt);
			msr_pkg::OP_TARGET: if (!m_flt) begin
				if (t > lim) t = lim;
				if (t < -lim) t = -lim;
				m_req = msr_pkg::SpdW'(t);
			end
			msr_pkg::OP_ENABLE: if (!f) m_en = 1'b0; else if (!m_flt) m_en = 1'b1;
			msr_pkg::OP_FAULT: if (f) begin
				m_flt = 1'b1;
				m_en = 1'b0;
			end else m_flt = 1'b0;
			msr_pkg::OP_POS_RESET: m_pos = '0;
			msr_pkg::OP_SEED: m_seed = (seed != 0) ? seed : msr_pkg::SeedDefault;
			default: ;
		endcase
		r.req = m_req;
		r.sp = m_sp;
		r.act = m_act;
		r.pos = m_pos;
		r.run = m_en && !m_flt;
		r.flt = m_flt;
		return r;
	endfunction

	// receiver: random stalls plus optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		speed_state_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item");
			end else begin
				e = expected_q.pop_front();
				if ({requested_speed, setpoint_speed, actual_speed, position, running,
						fault_active} !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp req %0d sp %0d act %0d pos %0d run %b flt %b",
							" / got %0d %0d %0d %0d %b %b"},
							e.req, e.sp, e.act, e.pos, e.run, e.flt, requested_speed,
							setpoint_speed, actual_speed, position, running, fault_active);
				end
			end
		end
	end

	// valid stays up after the accepting edge until the next item or an idle cycle
	task automatic send_item(logic [2:0] op, logic [msr_pkg::DtW-1:0] dt,
			logic signed [msr_pkg::SpdW-1:0] tgt, logic f, logic [31:0] seed);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		tick_length <= dt;
		target_speed <= tgt;
		flag <= f;
		new_seed <= seed;
		expected_q.push_back(predict_item(op, dt, tgt, f, seed));
		// ready is settled mid-cycle, the item is taken at the next rising edge
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(msr_pkg::cfg_idx_t idx, logic [27:0] val);
		logic [27:0] masked;
		masked = (idx == msr_pkg::CFG_LIMIT) ? (val & 28'h07FFFFF) :
			(idx == msr_pkg::CFG_RATIO) ? (val & 28'h000FFFF) : val;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_reg[idx] = masked;
		@(posedge clk);
	endtask

	task automatic test_directed;
		send_item(msr_pkg::OP_TICK, 21'd1000, '0, 1'b0, '0);
		send_item(msr_pkg::OP_TARGET, '0, 24'sh7FFFFF, 1'b0, '0);
		send_item(msr_pkg::OP_ENABLE, '0, '0, 1'b1, '0);
		send_item(msr_pkg::OP_TICK, 21'd0, '0, 1'b0, '0);
		send_item(msr_pkg::OP_TICK, 21'h100000, '0, 1'b0, '0);
		send_item(msr_pkg::OP_TICK, 21'h1FFFFF, '0, 1'b0, '0);
		repeat (4) send_item(msr_pkg::OP_TICK, 21'h1FFFFF, '0, 1'b0, '0);
		send_item(msr_pkg::OP_TARGET, '0, -24'sd8388608, 1'b0, '0);
		send_item(msr_pkg::OP_TICK, 21'h1FFFFF, '0, 1'b0, '0);
		send_item(msr_pkg::OP_SEED, '0, '0, 1'b0, 32'd0);
		send_item(msr_pkg::OP_SEED, '0, '0, 1'b0, 32'hFFFFFFFF);
		send_item(msr_pkg::OP_FAULT, '0, '0, 1'b1, '0);
		send_item(msr_pkg::OP_TARGET, '0, 24'sd1000, 1'b0, '0);
		send_item(msr_pkg::OP_ENABLE, '0, '0, 1'b1, '0);
		send_item(msr_pkg::OP_TICK, 21'h0FFFFF, '0, 1'b0, '0);
		send_item(msr_pkg::OP_FAULT, '0, '0, 1'b0, '0);
		send_item(msr_pkg::OP_ENABLE, '0, '0, 1'b1, '0);
		send_item(msr_pkg::OP_ENABLE, '0, '0, 1'b0, '0);
		send_item(msr_pkg::OP_POS_RESET, '0, '0, 1'b0, '0);
		// unused operation codes
		send_item(3'd6, 21'h1FFFFF, 24'sh7FFFFF, 1'b1, 32'hFFFFFFFF);
		send_item(3'd7, '0, '0, 1'b0, '0);
		drain();
	endtask

	task automatic random_items(int n);
		logic [2:0] op;
		logic [msr_pkg::DtW-1:0] dt;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 55) op = msr_pkg::OP_TICK;
			else if (k < 70) op = msr_pkg::OP_TARGET;
			else if (k < 82) op = msr_pkg::OP_ENABLE;
			else if (k < 88) op = msr_pkg::OP_FAULT;
			else if (k < 92) op = msr_pkg::OP_POS_RESET;
			else if (k < 97) op = msr_pkg::OP_SEED;
			else op = 3'($urandom_range(7));
			dt = ($urandom_range(9) == 0) ? msr_pkg::DtW'($urandom)
				: msr_pkg::DtW'($urandom_range(20000));
			// mostly enable so ticks reach ramp and noise behavior
			send_item(op, dt, msr_pkg::SpdW'($urandom),
				(op == msr_pkg::OP_FAULT) ? ($urandom_range(3) == 0)
				: ($urandom_range(4) != 0), $urandom);
		end
	endtask

	task automatic test_config_sweep;
		write_reg(msr_pkg::CFG_SP_ACC, 28'hFFFFFFF);
		write_reg(msr_pkg::CFG_SP_DEC, 28'hFFFFFFF);
		write_reg(msr_pkg::CFG_MO_ACC, 28'hFFFFFFF);
		write_reg(msr_pkg::CFG_MO_DEC, 28'hFFFFFFF);
		write_reg(msr_pkg::CFG_LIMIT, 28'h7FFFFF);
		write_reg(msr_pkg::CFG_RATIO, 28'hFFFF);
		random_items(150);
		drain();
		write_reg(msr_pkg::CFG_SP_ACC, 28'd0);
		write_reg(msr_pkg::CFG_MO_DEC, 28'd0);
		write_reg(msr_pkg::CFG_LIMIT, 28'd0);
		write_reg(msr_pkg::CFG_RATIO, 28'd0);
		random_items(100);
		drain();
		for (int i = 0; i < 4; i++) write_reg(msr_pkg::cfg_idx_t'(i), 28'($urandom));
		write_reg(msr_pkg::CFG_LIMIT, 28'($urandom));
		write_reg(msr_pkg::CFG_RATIO, 28'($urandom));
		random_items(150);
		drain();
	endtask

	task automatic test_backpressure;
		hold_off = 300;
		random_items(40);
		drain();
	endtask

	initial begin
		rate_reg[0] = 28'd256000;
		rate_reg[1] = 28'd256000;
		rate_reg[2] = 28'd204800;
		rate_reg[3] = 28'd204800;
		rate_reg[4] = 28'd768000;
		rate_reg[5] = 28'd655;
		m_req = '0;
		m_sp = '0;
		m_act = '0;
		m_pos = '0;
		m_seed = msr_pkg::SeedDefault;
		m_en = 1'b0;
		m_flt = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 6;
		recv_idle = 77;
		test_directed();
		random_items(300);
		drain();
		send_idle = 77;
		recv_idle = 6;
		test_config_sweep();
		send_idle = 0;
		recv_idle = 0;
		write_reg(msr_pkg::CFG_SP_ACC, 28'd256000);
		write_reg(msr_pkg::CFG_SP_DEC, 28'd256000);
		write_reg(msr_pkg::CFG_MO_ACC, 28'd204800);
		write_reg(msr_pkg::CFG_MO_DEC, 28'd204800);
		write_reg(msr_pkg::CFG_LIMIT, 28'd768000);
		write_reg(msr_pkg::CFG_RATIO, 28'd655);
		random_items(450);
		drain();
		test_backpressure();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
